// ----- rtl/ttip_pkg.sv -----
package ttip_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int CFG_ADDR_W     = 3;
	localparam int CFG_DATA_W     = 32;
	localparam int BASE_W         = 5;
	localparam int DIGIT_W        = 6;

	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_X_LOWER = 8'h78;
	localparam logic [7:0] CH_X_UPPER = 8'h58;
	localparam logic [7:0] CH_H_LOWER = 8'h68;

	localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
	localparam logic [BASE_W-1:0] BASE_OCT = 5'd8;
	localparam logic [BASE_W-1:0] BASE_DEC = 5'd10;
	localparam logic [BASE_W-1:0] BASE_HEX = 5'd16;

	typedef enum logic [2:0] {
		PH_START,
		PH_FIRST,
		PH_ZERO,
		PH_DEC,
		PH_OCT,
		PH_HEX
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_DIGIT,
		ST_SIGN_REJ,
		ST_BAD_BASE
	} status_t;

	typedef enum logic {
		REG_BASE_SELECT,
		REG_UNSIGNED_ONLY
	} reg_idx_t;

	typedef struct packed {
		logic [BASE_W-1:0] base_select;
		logic              unsigned_only;
	} cfg_t;

	typedef struct packed {
		logic    negative;
		status_t status;
	} res_flags_t;

	// 0..35 for 0-9, A-Z, a-z; 36 for anything else
	function automatic logic [DIGIT_W-1:0] digit_value(input logic [7:0] c);
		logic [DIGIT_W-1:0] d;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = DIGIT_W'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			d = DIGIT_W'(c - 8'h41 + 8'd10);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = DIGIT_W'(c - 8'h61 + 8'd10);
		end else begin
			d = 6'd36;
		end
		return d;
	endfunction

endpackage

// ----- rtl/ttip_in_if.sv -----
interface ttip_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ----- rtl/ttip_out_if.sv -----
interface ttip_out_if #(
	parameter int VALUE_BITS = ttip_pkg::VALUE_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic [VALUE_BITS-1:0]   magnitude;
	logic                    negative;
	ttip_pkg::status_t       status;

	modport source (output valid, output magnitude, output negative, output status, input ready);
	modport sink (input valid, input magnitude, input negative, input status, output ready);
endinterface

// ----- rtl/ttip_apb_regs.sv -----
module ttip_apb_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ttip_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [ttip_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [ttip_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready,
	output ttip_pkg::cfg_t                    cfg
);

	ttip_pkg::cfg_t     cfg_q;
	ttip_pkg::reg_idx_t reg_idx;
	logic               wr_en;

	assign pready  = 1'b1;
	assign reg_idx = ttip_pkg::reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				ttip_pkg::REG_BASE_SELECT: begin
					cfg_q.base_select <= pwdata[ttip_pkg::BASE_W-1:0];
				end
				ttip_pkg::REG_UNSIGNED_ONLY: begin
					cfg_q.unsigned_only <= pwdata[0];
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			ttip_pkg::REG_BASE_SELECT: begin
				prdata[ttip_pkg::BASE_W-1:0] = cfg_q.base_select;
			end
			ttip_pkg::REG_UNSIGNED_ONLY: begin
				prdata[0] = cfg_q.unsigned_only;
			end
		endcase
	end

endmodule

// ----- rtl/ttip_scan.sv -----
module ttip_scan #(
	parameter int VALUE_BITS = ttip_pkg::VALUE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ttip_pkg::cfg_t           cfg,
	ttip_in_if.sink                  chars,
	input  logic                     res_stall,
	output logic                     res_load,
	output logic [VALUE_BITS-1:0]    res_mag,
	output ttip_pkg::res_flags_t     res_flags
);

	logic                    vld_s1;
	logic [7:0]              char_s1;
	logic                    last_s1;
	logic                    adv;

	ttip_pkg::phase_t        phase_q, phase_d;
	logic                    sign_q, sign_d;
	logic [VALUE_BITS-1:0]   main_q, main_d;
	logic                    merr_q, merr_d;
	logic [VALUE_BITS-1:0]   suf_q, suf_d;
	logic                    serr_q, serr_d;

	logic                        consumed;
	logic                        to_hex;
	logic                        forced_ok;
	logic [ttip_pkg::BASE_W-1:0] mb, sb;
	logic [ttip_pkg::DIGIT_W-1:0] dig;
	logic                        m_ok, s_ok;
	logic [VALUE_BITS-1:0]       m_next, s_next;
	logic                        use_suf;
	logic [VALUE_BITS-1:0]       mag;
	logic                        err;
	ttip_pkg::status_t           status;

	// input stage; a last char waits here while the result slot is full
	assign adv         = vld_s1 && !(last_s1 && res_stall);
	assign chars.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (chars.ready) begin
			vld_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.last_char;
		end
	end

	// prefix grammar
	always_comb begin
		phase_d  = phase_q;
		sign_d   = sign_q;
		consumed = 1'b0;
		to_hex   = 1'b0;
		unique case (phase_q)
			ttip_pkg::PH_START: begin
				if (char_s1 == ttip_pkg::CH_MINUS || char_s1 == ttip_pkg::CH_PLUS) begin
					phase_d  = ttip_pkg::PH_FIRST;
					sign_d   = (char_s1 == ttip_pkg::CH_MINUS);
					consumed = 1'b1;
				end else begin
					phase_d = (char_s1 == ttip_pkg::CH_ZERO) ? ttip_pkg::PH_ZERO
						: ttip_pkg::PH_DEC;
				end
			end
			ttip_pkg::PH_FIRST: begin
				phase_d = (char_s1 == ttip_pkg::CH_ZERO) ? ttip_pkg::PH_ZERO
					: ttip_pkg::PH_DEC;
			end
			ttip_pkg::PH_ZERO: begin
				if ((char_s1 == ttip_pkg::CH_X_LOWER || char_s1 == ttip_pkg::CH_X_UPPER)
						&& !last_s1) begin
					phase_d  = ttip_pkg::PH_HEX;
					consumed = 1'b1;
					to_hex   = 1'b1;
				end else begin
					phase_d = ttip_pkg::PH_OCT;
				end
			end
			ttip_pkg::PH_DEC, ttip_pkg::PH_OCT, ttip_pkg::PH_HEX: begin
				phase_d = phase_q;
			end
			default: begin
				phase_d = ttip_pkg::PH_DEC;
			end
		endcase
	end

	// digit bases
	assign forced_ok = (cfg.base_select >= ttip_pkg::BASE_MIN)
		&& (cfg.base_select <= ttip_pkg::BASE_HEX);

	always_comb begin
		if (forced_ok) begin
			mb = cfg.base_select;
			sb = cfg.base_select;
		end else if (cfg.base_select != '0) begin
			mb = ttip_pkg::BASE_HEX;
			sb = ttip_pkg::BASE_HEX;
		end else begin
			sb = ttip_pkg::BASE_HEX;
			priority if (phase_d == ttip_pkg::PH_HEX) begin
				mb = ttip_pkg::BASE_HEX;
			end else if (phase_d == ttip_pkg::PH_ZERO || phase_d == ttip_pkg::PH_OCT) begin
				mb = ttip_pkg::BASE_OCT;
			end else begin
				mb = ttip_pkg::BASE_DEC;
			end
		end
	end

	assign dig    = ttip_pkg::digit_value(char_s1);
	assign m_ok   = dig < {1'b0, mb};
	assign s_ok   = dig < {1'b0, sb};
	assign m_next = main_q * VALUE_BITS'(mb) + VALUE_BITS'(dig);
	assign s_next = suf_q * VALUE_BITS'(sb) + VALUE_BITS'(dig);

	always_comb begin
		if (to_hex) begin
			main_d = '0;
			merr_d = 1'b0;
		end else if (consumed) begin
			main_d = main_q;
			merr_d = merr_q;
		end else begin
			main_d = m_ok ? m_next : main_q;
			merr_d = merr_q || !m_ok;
		end
		if (consumed) begin
			suf_d  = suf_q;
			serr_d = serr_q;
		end else begin
			suf_d  = s_ok ? s_next : suf_q;
			serr_d = serr_q || !s_ok;
		end
	end

	// result at the last char; a trailing 'h' falls back to the suffix run (hex, or the forced base)
	assign use_suf = !consumed && (char_s1 == ttip_pkg::CH_H_LOWER)
		&& (phase_d != ttip_pkg::PH_HEX);
	assign mag     = use_suf ? suf_q : main_d;
	assign err     = use_suf ? serr_q : merr_d;

	always_comb begin
		priority if (cfg.unsigned_only && sign_d) begin
			status = ttip_pkg::ST_SIGN_REJ;
		end else if (cfg.base_select != '0 && !forced_ok) begin
			status = ttip_pkg::ST_BAD_BASE;
		end else if (err) begin
			status = ttip_pkg::ST_BAD_DIGIT;
		end else begin
			status = ttip_pkg::ST_OK;
		end
	end

	assign res_load           = adv && last_s1;
	assign res_mag            = (status == ttip_pkg::ST_OK) ? mag : '0;
	assign res_flags.negative = (status == ttip_pkg::ST_OK) && sign_d;
	assign res_flags.status   = status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ttip_pkg::PH_START;
			sign_q  <= 1'b0;
			main_q  <= '0;
			merr_q  <= 1'b0;
			suf_q   <= '0;
			serr_q  <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				phase_q <= ttip_pkg::PH_START;
				sign_q  <= 1'b0;
				main_q  <= '0;
				merr_q  <= 1'b0;
				suf_q   <= '0;
				serr_q  <= 1'b0;
			end else begin
				phase_q <= phase_d;
				sign_q  <= sign_d;
				main_q  <= main_d;
				merr_q  <= merr_d;
				suf_q   <= suf_d;
				serr_q  <= serr_d;
			end
		end
	end

`ifndef SYNTH
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (phase_q == ttip_pkg::PH_START) && !sign_q && !merr_q && !serr_q)
		else $error("number state not cleared after last char");

	a_failed_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && (res_flags.status != ttip_pkg::ST_OK)
		|-> (res_mag == '0) && !res_flags.negative)
		else $error("failed result carries a value");

	a_sign_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sign_q) |-> ($past(phase_q) == ttip_pkg::PH_START))
		else $error("sign taken outside the first char");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && last_s1 && res_stall |=> vld_s1 && last_s1 && $stable(char_s1))
		else $error("last char lost while result slot full");
`endif

endmodule

// ----- rtl/ttip_out_reg.sv -----
module ttip_out_reg #(
	parameter int VALUE_BITS = ttip_pkg::VALUE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     res_load,
	input  logic [VALUE_BITS-1:0]    res_mag,
	input  ttip_pkg::res_flags_t     res_flags,
	output logic                     res_stall,
	ttip_out_if.source               result
);

	logic                    valid_q;
	logic [VALUE_BITS-1:0]   mag_q;
	ttip_pkg::res_flags_t    flags_q;

	assign res_stall        = valid_q && !result.ready;
	assign result.valid     = valid_q;
	assign result.magnitude = mag_q;
	assign result.negative  = flags_q.negative;
	assign result.status    = flags_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			mag_q   <= res_mag;
			flags_q <= res_flags;
		end
	end

endmodule

// ----- rtl/text_to_integer_parser_top.sv -----
// Streaming text-to-integer parser. One character beat per clock is taken on chars, but a
// last_char beat is held while the previous result is untaken; it yields one result beat
// (magnitude, negative, status) via the input stage and a registered output, and the next
// number's characters up to its last keep flowing in while that result waits. The rate is
// set by the per-character accumulate (value times base plus digit) being combinational.
// Base detection, sign and the trailing 'h' suffix are resolved on the fly with a parallel
// hex (or forced-base) accumulator. base_select (offset 0) and unsigned_only (offset 4) are
// written over APB only while the parser is idle: a rule for the user, not enforced here.
module text_to_integer_parser_top #(
	parameter int VALUE_BITS = ttip_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ttip_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [ttip_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [ttip_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready,
	ttip_in_if.sink                           chars,
	ttip_out_if.source                        result
);

	ttip_pkg::cfg_t          cfg;
	logic                    res_load;
	logic                    res_stall;
	logic [VALUE_BITS-1:0]   res_mag;
	ttip_pkg::res_flags_t    res_flags;

	ttip_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ttip_scan #(
		.VALUE_BITS (VALUE_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.chars     (chars),
		.res_stall (res_stall),
		.res_load  (res_load),
		.res_mag   (res_mag),
		.res_flags (res_flags)
	);

	ttip_out_reg #(
		.VALUE_BITS (VALUE_BITS)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_load  (res_load),
		.res_mag   (res_mag),
		.res_flags (res_flags),
		.res_stall (res_stall),
		.result    (result)
	);

endmodule

// ----- tb/sv/text_to_integer_parser_top_tb.sv -----
module text_to_integer_parser_top_tb;

	localparam int SETTLE_CYCLES = 6;

	typedef logic [7:0] text_q_t[$];

	typedef struct packed {
		logic [63:0]       magnitude;
		logic              negative;
		ttip_pkg::status_t status;
	} parse_res_t;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [ttip_pkg::CFG_ADDR_W-1:0] paddr;
	logic [ttip_pkg::CFG_DATA_W-1:0] pwdata;
	logic [ttip_pkg::CFG_DATA_W-1:0] prdata;
	logic                            pready;

	ttip_in_if chars_if();
	ttip_out_if #(.VALUE_BITS(64)) result_if();

	text_to_integer_parser_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.chars  (chars_if),
		.result (result_if)
	);

	// parser model state and register copies
	ttip_pkg::phase_t ph;
	logic             neg_seen;
	logic [63:0]      run_val;
	logic             run_bad;
	logic [63:0]      hsuf_val;
	logic             hsuf_bad;
	logic [4:0]       cfg_base;
	logic             cfg_unsigned;

	parse_res_t  pending_results[$];
	int          errors;
	int          chars_sent;
	bit          src_idle;
	bit          snk_idle;
	int          hold_req;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	initial begin
		#5000000;
		$display("text_to_integer_parser_top verification failed");
		$finish;
	end

	function automatic int char_digit(input logic [7:0] c);
		int v;
		v = int'(c);
		if (v >= 48 && v < 58) begin
			return v - 48;
		end
		if (v >= 65 && v < 91) begin
			return v - 55;
		end
		if (v >= 97 && v < 123) begin
			return v - 87;
		end
		return 36;
	endfunction

	function automatic void fold_digit(input logic [7:0] c, input int base,
			inout logic [63:0] acc, inout logic bad);
		int d;
		d = char_digit(c);
		if (d >= base) begin
			bad = 1'b1;
		end else begin
			acc = acc * 64'(base) + 64'(d);
		end
	endfunction

	function automatic void clear_parse();
		ph       = ttip_pkg::PH_START;
		neg_seen = 1'b0;
		run_val  = '0;
		run_bad  = 1'b0;
		hsuf_val = '0;
		hsuf_bad = 1'b0;
	endfunction

	function automatic bit predict_char(input logic [7:0] c, input logic last,
			output parse_res_t r);
		bit                taken;
		bit                forced_ok;
		bit                suffix_used;
		int                mb;
		int                sb;
		logic [63:0]       prev_val;
		logic              prev_bad;
		logic [63:0]       mag;
		logic              bad;
		ttip_pkg::status_t st;
		taken    = 1'b0;
		prev_val = hsuf_val;
		prev_bad = hsuf_bad;
		r        = '0;
		case (ph)
			ttip_pkg::PH_START: begin
				if (c == ttip_pkg::CH_MINUS || c == ttip_pkg::CH_PLUS) begin
					neg_seen = (c == ttip_pkg::CH_MINUS);
					taken    = 1'b1;
					ph       = ttip_pkg::PH_FIRST;
				end else begin
					ph = (c == ttip_pkg::CH_ZERO) ? ttip_pkg::PH_ZERO : ttip_pkg::PH_DEC;
				end
			end
			ttip_pkg::PH_FIRST: begin
				ph = (c == ttip_pkg::CH_ZERO) ? ttip_pkg::PH_ZERO : ttip_pkg::PH_DEC;
			end
			ttip_pkg::PH_ZERO: begin
				if ((c == ttip_pkg::CH_X_LOWER || c == ttip_pkg::CH_X_UPPER) && !last) begin
					ph      = ttip_pkg::PH_HEX;
					run_val = '0;
					run_bad = 1'b0;
					taken   = 1'b1;
				end else begin
					ph = ttip_pkg::PH_OCT;
				end
			end
			default: ;
		endcase
		forced_ok = cfg_base >= 5'd2 && cfg_base <= 5'd16;
		if (!taken) begin
			if (forced_ok) begin
				mb = int'(cfg_base);
				sb = int'(cfg_base);
			end else if (cfg_base != 5'd0) begin
				mb = 16;
				sb = 16;
			end else begin
				sb = 16;
				if (ph == ttip_pkg::PH_HEX) begin
					mb = 16;
				end else if (ph == ttip_pkg::PH_ZERO || ph == ttip_pkg::PH_OCT) begin
					mb = 8;
				end else begin
					mb = 10;
				end
			end
			fold_digit(c, mb, run_val, run_bad);
			fold_digit(c, sb, hsuf_val, hsuf_bad);
		end
		if (!last) begin
			return 1'b0;
		end
		suffix_used = !taken && c == ttip_pkg::CH_H_LOWER && ph != ttip_pkg::PH_HEX;
		mag = suffix_used ? prev_val : run_val;
		bad = suffix_used ? prev_bad : run_bad;
		if (cfg_unsigned && neg_seen) begin
			st = ttip_pkg::ST_SIGN_REJ;
		end else if (cfg_base != 5'd0 && !forced_ok) begin
			st = ttip_pkg::ST_BAD_BASE;
		end else if (bad) begin
			st = ttip_pkg::ST_BAD_DIGIT;
		end else begin
			st = ttip_pkg::ST_OK;
		end
		r.magnitude = (st == ttip_pkg::ST_OK) ? mag : '0;
		r.negative  = (st == ttip_pkg::ST_OK) && neg_seen;
		r.status    = st;
		clear_parse();
		return 1'b1;
	endfunction

	// result checker
	always @(posedge clk) begin
		parse_res_t e;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result beat: magnitude %h negative %b status %0d",
					$time, result_if.magnitude, result_if.negative, result_if.status);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (result_if.magnitude !== e.magnitude) begin
					$display("%0t magnitude mismatch: expected %h actual %h",
						$time, e.magnitude, result_if.magnitude);
					errors++;
				end
				if (result_if.negative !== e.negative) begin
					$display("%0t negative mismatch: expected %b actual %b",
						$time, e.negative, result_if.negative);
					errors++;
				end
				if (result_if.status !== e.status) begin
					$display("%0t status mismatch: expected %0d actual %0d",
						$time, e.status, result_if.status);
					errors++;
				end
			end
		end
	end

	// result receiver: random stalls per beat when snk_idle, plus long hold-offs on request
	initial begin
		int w;
		result_if.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			w = snk_idle ? $urandom_range(0, 11) : 0;
			if (hold_req > 0) begin
				w        = hold_req;
				hold_req = 0;
			end
			if (w > 0) begin
				result_if.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid && hold_req == 0);
		end
	end

	task automatic send_char(input logic [7:0] c, input logic last);
		int         gap;
		parse_res_t r;
		gap = src_idle ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= c;
		chars_if.last_char <= last;
		do @(posedge clk); while (!chars_if.ready);
		if (predict_char(c, last, r)) begin
			pending_results.push_back(r);
		end
		chars_sent++;
	endtask

	task automatic send_number(input text_q_t q);
		foreach (q[i]) begin
			send_char(q[i], i == q.size() - 1);
		end
	endtask

	task automatic send_text(input string s);
		text_q_t q;
		for (int i = 0; i < s.len(); i++) begin
			q.push_back(s[i]);
		end
		send_number(q);
	endtask

	task automatic settle();
		chars_if.valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input ttip_pkg::reg_idx_t idx, input logic [31:0] v);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ttip_pkg::CFG_ADDR_W'({idx, 2'b00});
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == ttip_pkg::REG_BASE_SELECT) begin
			cfg_base = v[4:0];
		end else begin
			cfg_unsigned = v[0];
		end
	endtask

	task automatic set_cfg(input logic [4:0] base, input logic uns);
		cfg_write(ttip_pkg::REG_BASE_SELECT, 32'(base));
		cfg_write(ttip_pkg::REG_UNSIGNED_ONLY, 32'(uns));
	endtask

	function automatic logic [7:0] rand_digit(input int base);
		int v;
		v = $urandom_range(0, base - 1);
		if (v < 10) begin
			return 8'(48 + v);
		end
		return 8'(($urandom_range(0, 1) ? 65 : 97) + v - 10);
	endfunction

	function automatic logic [4:0] pick_base();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			return 5'd0;
		end
		if (r < 8) begin
			return 5'($urandom_range(2, 16));
		end
		if (r == 8) begin
			return 5'd1;
		end
		return 5'($urandom_range(17, 31));
	endfunction

	task automatic make_number(output text_q_t q);
		int  kind;
		int  len;
		int  db;
		bit  forced_ok;
		q = {};
		kind      = $urandom_range(0, 99);
		len       = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
		forced_ok = cfg_base >= 5'd2 && cfg_base <= 5'd16;
		if ($urandom_range(0, 3) == 0) begin
			q.push_back($urandom_range(0, 1) ? ttip_pkg::CH_MINUS : ttip_pkg::CH_PLUS);
		end
		if (kind < 25) begin
			db = 10;
		end else if (kind < 40) begin
			db = 8;
			q.push_back(ttip_pkg::CH_ZERO);
		end else if (kind < 60) begin
			db = 16;
			q.push_back(ttip_pkg::CH_ZERO);
			q.push_back($urandom_range(0, 1) ? ttip_pkg::CH_X_LOWER : ttip_pkg::CH_X_UPPER);
		end else if (kind < 90) begin
			db = (kind < 78) ? 16 : $urandom_range(2, 36);
		end else begin
			db = 0;
		end
		if (forced_ok && db != 0 && $urandom_range(0, 1)) begin
			db = int'(cfg_base);
		end
		for (int i = 0; i < len; i++) begin
			q.push_back((db == 0) ? 8'($urandom_range(1, 255)) : rand_digit(db));
		end
		if (kind >= 60 && kind < 78) begin
			q.push_back(ttip_pkg::CH_H_LOWER);
		end
		if (q.size() == 0) begin
			q.push_back(rand_digit(10));
		end
		if ($urandom_range(0, 9) == 0) begin
			q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(1, 255));
		end
	endtask

	task automatic test_text_forms();
		src_idle = 1'b1;
		snk_idle = 1'b1;
		set_cfg(5'd0, 1'b0);
		send_text("0");
		send_text("-");
		send_text("+");
		send_text("h");
		send_text("-h");
		send_text("0x");
		send_text("0x1h");
		send_text("0X7fA");
		send_text("-1Fh");
		send_text("+017");
		send_text("09");
		send_number({8'hFF});
		send_number({8'h01, 8'h00});
	endtask

	task automatic test_forced_and_bad_base();
		set_cfg(5'd16, 1'b0);
		send_text("-ffh");
		set_cfg(5'd2, 1'b0);
		send_text("102");
		set_cfg(5'd1, 1'b0);
		send_text("z");
		set_cfg(5'd31, 1'b0);
		send_text("0x5");
	endtask

	task automatic test_sign_policy();
		set_cfg(5'd0, 1'b1);
		send_text("-5");
		send_text("+5");
		set_cfg(5'd17, 1'b1);
		send_text("-7g");
	endtask

	task automatic test_random_numbers();
		int      target;
		int      n;
		text_q_t q;
		target = chars_sent + 340;
		n      = 0;
		while (chars_sent < target) begin
			if (n % 12 == 0) begin
				set_cfg(pick_base(), $urandom_range(0, 2) == 0);
			end
			if (n % 30 == 0) begin
				src_idle = $urandom_range(0, 2) != 0;
				snk_idle = $urandom_range(0, 2) != 0;
			end
			make_number(q);
			send_number(q);
			n++;
		end
	endtask

	task automatic test_backpressure();
		text_q_t q;
		set_cfg(5'd0, 1'b0);
		src_idle = 1'b0;
		snk_idle = 1'b0;
		hold_req = 300;
		for (int i = 0; i < 40; i++) begin
			if (i % 4 == 3) begin
				make_number(q);
				send_number(q);
			end else begin
				send_char(rand_digit(10), 1'b1);
			end
		end
		settle();
		snk_idle = 1'b1;
		src_idle = 1'b1;
		for (int i = 0; i < 5; i++) begin
			make_number(q);
			send_number(q);
		end
	endtask

	initial begin
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		chars_if.valid     = 1'b0;
		chars_if.char_code = '0;
		chars_if.last_char = 1'b0;
		errors             = 0;
		chars_sent         = 0;
		src_idle           = 1'b0;
		snk_idle           = 1'b0;
		hold_req           = 0;
		cfg_base           = 5'd0;
		cfg_unsigned       = 1'b0;
		clear_parse();
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_text_forms();
		test_forced_and_bad_base();
		test_sign_policy();
		test_random_numbers();
		test_backpressure();

		settle();
		if (errors == 0) begin
			$display("text_to_integer_parser_top verification clean");
		end else begin
			$display("text_to_integer_parser_top verification failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/ttip_pkg.sv
rtl/ttip_in_if.sv
rtl/ttip_out_if.sv
rtl/ttip_apb_regs.sv
rtl/ttip_scan.sv
rtl/ttip_out_reg.sv
rtl/text_to_integer_parser_top.sv
tb/sv/text_to_integer_parser_top_tb.sv
